// ----- design/iep_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// iep_pkg: shared types for the infix expression evaluator
// Holds the operator codes, the arithmetic unit operations, the state types
// and the command and status records between controller and datapath.
// ---------------------------------------------------------------------------
package iep_pkg;

  typedef enum logic [2:0] {
    OP_PLUS   = 3'd0,
    OP_MINUS  = 3'd1,
    OP_TIMES  = 3'd2,
    OP_DIVIDE = 3'd3,
    OP_END    = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    FPU_ADD,
    FPU_SUB,
    FPU_MUL,
    FPU_DIV
  } fpu_op_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_PRENORM,
    FS_DIVIDE,
    FS_PRODUCT,
    FS_NORM,
    FS_ROUND,
    FS_DONE
  } fpu_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_TERM,
    CS_TERM_WAIT,
    CS_DECIDE,
    CS_SUM_WAIT,
    CS_EMIT
  } ctrl_state_t;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic    load_in;
    logic    fpu_start;
    fpu_op_t fpu_op;
    logic    take_term;
    logic    commit_term;
    logic    commit_sum;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic     term_pending;
    logic     divide_pending;
    logic     additive_minus;
    op_code_t op;
    logic     fpu_done;
    logic     out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/iep_fpu.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// iep_fpu: sequential single precision add, subtract, multiply and divide
// Special operands are settled in the start cycle. Division is restoring,
// one quotient bit a cycle. Normalisation shifts one place a cycle, then a
// single round-to-nearest-even step packs the result.
// ---------------------------------------------------------------------------
module iep_fpu (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire iep_pkg::fpu_op_t op,
  input  wire logic [31:0]    a,
  input  wire logic [31:0]    b,
  output logic                done,
  output logic [31:0]         result
);

  iep_pkg::fpu_state_t state, state_next;

  logic               sign;
  logic signed [11:0] e;
  logic [49:0]        m;
  logic               stk;
  logic [23:0]        ma, mb;
  logic signed [11:0] ea, eb;
  logic [25:0]        rem;
  logic [26:0]        q;
  logic [4:0]         cnt;

  // Operand decode.
  logic               sa, sb, sb_eff, sx;
  logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0]        mant_a, mant_b;
  logic signed [11:0] eeff_a, eeff_b;

  always_comb begin
    sa     = a[31];
    sb     = b[31];
    sb_eff = b[31] ^ (op == iep_pkg::FPU_SUB);
    sx     = a[31] ^ b[31];
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    mant_a = {(a[30:23] != 8'd0), a[22:0]};
    mant_b = {(b[30:23] != 8'd0), b[22:0]};
    eeff_a = {4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]};
    eeff_b = {4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]};
  end

  // Alignment and add or subtract of the two magnitudes.
  logic               a_big, s_big;
  logic [23:0]        mant_big, mant_sml;
  logic signed [11:0] e_big, e_diff;
  logic [49:0]        full_s, shifted_s, m_big, m_sml, m_sum;
  logic               lost;

  always_comb begin
    a_big     = (a[30:0] >= b[30:0]);
    s_big     = a_big ? sa : sb_eff;
    mant_big  = a_big ? mant_a : mant_b;
    mant_sml  = a_big ? mant_b : mant_a;
    e_big     = a_big ? eeff_a : eeff_b;
    e_diff    = a_big ? (eeff_a - eeff_b) : (eeff_b - eeff_a);
    full_s    = {1'b0, mant_sml, 25'd0};
    if (e_diff >= 12'sd50) begin
      shifted_s = 50'd0;
      lost      = |full_s;
    end else begin
      shifted_s = full_s >> e_diff[5:0];
      lost      = |(full_s & ~({50{1'b1}} << e_diff[5:0]));
    end
    m_big = {1'b0, mant_big, 25'd0};
    m_sml = shifted_s | {49'd0, lost};
    if (sa == sb_eff) begin
      m_sum = m_big + m_sml;
    end else begin
      m_sum = m_big - m_sml;
    end
  end

  // Division step.
  logic        div_ge;
  logic [25:0] rem_sub;
  logic [26:0] q_new;

  always_comb begin
    div_ge  = (rem >= {2'b00, mb});
    rem_sub = div_ge ? (rem - {2'b00, mb}) : rem;
    q_new   = {q[25:0], div_ge};
  end

  logic [47:0] prod;
  assign prod = 48'(ma) * 48'(mb);

  // Rounding.
  logic [23:0]        r_mant, r_mant2;
  logic               r_guard, r_sticky, r_inc;
  logic [24:0]        r_sum;
  logic signed [11:0] r_e;

  always_comb begin
    r_mant   = m[49:26];
    r_guard  = m[25];
    r_sticky = (|m[24:0]) | stk;
    r_inc    = r_guard & (r_sticky | r_mant[0]);
    r_sum    = {1'b0, r_mant} + {24'd0, r_inc};
    if (r_sum[24]) begin
      r_mant2 = 24'h80_0000;
      r_e     = e + 12'sd1;
    end else begin
      r_mant2 = r_sum[23:0];
      r_e     = e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iep_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      iep_pkg::FS_IDLE:    if (start) state_next = iep_pkg::FS_DONE;
      iep_pkg::FS_PRENORM: if (ma[23] && mb[23]) state_next = iep_pkg::FS_DIVIDE;
      iep_pkg::FS_DIVIDE:  if (cnt == 5'd26) state_next = iep_pkg::FS_NORM;
      iep_pkg::FS_PRODUCT: state_next = iep_pkg::FS_NORM;
      iep_pkg::FS_NORM: begin
        if (m == 50'd0) begin
          state_next = iep_pkg::FS_DONE;
        end else if (!(e < 12'sd1) && !(!m[49] && e > 12'sd1)) begin
          state_next = iep_pkg::FS_ROUND;
        end
      end
      iep_pkg::FS_ROUND:   state_next = iep_pkg::FS_DONE;
      iep_pkg::FS_DONE: begin
        done       = 1'b1;
        state_next = iep_pkg::FS_IDLE;
      end
      default:             state_next = iep_pkg::FS_IDLE;
    endcase
    // Generic operands leave the start cycle for the arithmetic states.
    if (state == iep_pkg::FS_IDLE && start) begin
      case (op)
        iep_pkg::FPU_ADD, iep_pkg::FPU_SUB: begin
          if (!(nan_a || nan_b || inf_a || inf_b || (zero_a && zero_b))) begin
            state_next = iep_pkg::FS_NORM;
          end
        end
        iep_pkg::FPU_MUL: begin
          if (!(nan_a || nan_b || inf_a || inf_b)) state_next = iep_pkg::FS_PRODUCT;
        end
        iep_pkg::FPU_DIV: begin
          if (!(nan_a || nan_b || zero_b || inf_a || inf_b || zero_a)) begin
            state_next = iep_pkg::FS_PRENORM;
          end
        end
        default: state_next = iep_pkg::FS_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      iep_pkg::FS_IDLE: begin
        stk <= 1'b0;
        if (start) begin
          case (op)
            iep_pkg::FPU_ADD, iep_pkg::FPU_SUB: begin
              if (nan_a || nan_b || (inf_a && inf_b && (sa != sb_eff))) begin
                result <= iep_pkg::CANON_NAN;
              end else if (inf_a) begin
                result <= {sa, 8'hFF, 23'd0};
              end else if (inf_b) begin
                result <= {sb_eff, 8'hFF, 23'd0};
              end else if (zero_a && zero_b) begin
                result <= {sa & sb_eff, 31'd0};
              end
              sign <= (m_sum == 50'd0) ? 1'b0 : s_big;
              m    <= m_sum;
              e    <= e_big + 12'sd1;
            end
            iep_pkg::FPU_MUL: begin
              if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
                result <= iep_pkg::CANON_NAN;
              end else if (inf_a || inf_b) begin
                result <= {sx, 8'hFF, 23'd0};
              end
              sign <= sx;
              ma   <= mant_a;
              mb   <= mant_b;
              e    <= eeff_a + eeff_b - 12'sd126;
            end
            iep_pkg::FPU_DIV: begin
              if (nan_a || nan_b || (zero_a && zero_b) || (inf_a && inf_b)) begin
                result <= iep_pkg::CANON_NAN;
              end else if (zero_b || inf_a) begin
                result <= {sx, 8'hFF, 23'd0};
              end else if (inf_b || zero_a) begin
                result <= {sx, 31'd0};
              end
              sign <= sx;
              ma   <= mant_a;
              mb   <= mant_b;
              ea   <= eeff_a;
              eb   <= eeff_b;
            end
            default: result <= iep_pkg::CANON_NAN;
          endcase
        end
      end
      iep_pkg::FS_PRENORM: begin
        if (!ma[23]) begin
          ma <= {ma[22:0], 1'b0};
          ea <= ea - 12'sd1;
        end
        if (!mb[23]) begin
          mb <= {mb[22:0], 1'b0};
          eb <= eb - 12'sd1;
        end
        rem <= {2'b00, ma};
        q   <= 27'd0;
        cnt <= 5'd0;
      end
      iep_pkg::FS_DIVIDE: begin
        q   <= q_new;
        rem <= {rem_sub[24:0], 1'b0};
        cnt <= cnt + 5'd1;
        m   <= {q_new, 22'd0, (rem_sub != 26'd0)};
        e   <= ea - eb + 12'sd127;
      end
      iep_pkg::FS_PRODUCT: begin
        m <= {prod, 2'b00};
      end
      iep_pkg::FS_NORM: begin
        if (m == 50'd0) begin
          result <= {sign, 31'd0};
        end else if (e < 12'sd1) begin
          // Below the normal range: shift into the subnormal position.
          stk <= stk | m[0];
          m   <= {1'b0, m[49:1]};
          e   <= e + 12'sd1;
        end else if (!m[49] && e > 12'sd1) begin
          m <= {m[48:0], 1'b0};
          e <= e - 12'sd1;
        end
      end
      iep_pkg::FS_ROUND: begin
        if (r_e >= 12'sd255) begin
          result <= {sign, 8'hFF, 23'd0};
        end else begin
          result <= {sign, r_mant2[23] ? r_e[7:0] : 8'd0, r_mant2[22:0]};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/iep_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// iep_ctrl: sequencing controller
// Takes one item at a time, finishes the pending product term, then either
// keeps the term or folds it into the running sum and emits on the end mark.
// ---------------------------------------------------------------------------
module iep_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              operand_valid,
  output logic                   operand_stall,
  input  wire iep_pkg::dp_stat_t stat,
  output iep_pkg::dp_cmd_t       cmd
);

  iep_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iep_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    operand_stall = (state != iep_pkg::CS_IDLE);
    cmd           = '0;
    cmd.fpu_op    = iep_pkg::FPU_ADD;
    case (state)
      iep_pkg::CS_IDLE: begin
        if (operand_valid) begin
          cmd.load_in = 1'b1;
          state_next  = stat.term_pending ? iep_pkg::CS_TERM : iep_pkg::CS_DECIDE;
        end
      end
      iep_pkg::CS_TERM: begin
        cmd.fpu_start = 1'b1;
        cmd.fpu_op    = stat.divide_pending ? iep_pkg::FPU_DIV : iep_pkg::FPU_MUL;
        state_next    = iep_pkg::CS_TERM_WAIT;
      end
      iep_pkg::CS_TERM_WAIT: begin
        if (stat.fpu_done) begin
          cmd.take_term = 1'b1;
          state_next    = iep_pkg::CS_DECIDE;
        end
      end
      iep_pkg::CS_DECIDE: begin
        if (stat.op == iep_pkg::OP_TIMES || stat.op == iep_pkg::OP_DIVIDE) begin
          cmd.commit_term = 1'b1;
          state_next      = iep_pkg::CS_IDLE;
        end else begin
          cmd.fpu_start = 1'b1;
          cmd.fpu_op    = stat.additive_minus ? iep_pkg::FPU_SUB : iep_pkg::FPU_ADD;
          state_next    = iep_pkg::CS_SUM_WAIT;
        end
      end
      iep_pkg::CS_SUM_WAIT: begin
        if (stat.fpu_done) begin
          cmd.commit_sum = 1'b1;
          state_next     = (stat.op == iep_pkg::OP_END) ? iep_pkg::CS_EMIT
                                                        : iep_pkg::CS_IDLE;
        end
      end
      iep_pkg::CS_EMIT: begin
        // Wait until the output register is free before the transfer is set up.
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = iep_pkg::CS_IDLE;
        end
      end
      default: state_next = iep_pkg::CS_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/iep_dp.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// iep_dp: evaluator datapath
// Holds the expression state, the captured item, the current term and the
// output register, and owns the floating-point unit.
// ---------------------------------------------------------------------------
module iep_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire iep_pkg::dp_cmd_t cmd,
  output iep_pkg::dp_stat_t     stat,
  input  wire logic [31:0]      operand_bits,
  input  wire logic [2:0]       next_op,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [31:0]           result_bits
);

  logic [31:0]       running_sum;
  logic              additive_minus;
  logic [31:0]       product_term;
  logic              term_pending;
  logic              divide_pending;
  logic [31:0]       x_reg;
  logic [31:0]       t_reg;
  iep_pkg::op_code_t op_reg;

  logic        fpu_done;
  logic [31:0] fpu_a, fpu_b, fpu_result;

  iep_pkg::op_code_t op_in;
  assign op_in = (next_op > 3'd4) ? iep_pkg::OP_END : iep_pkg::op_code_t'(next_op);

  assign fpu_a = (cmd.fpu_op == iep_pkg::FPU_MUL || cmd.fpu_op == iep_pkg::FPU_DIV)
               ? product_term : running_sum;
  assign fpu_b = (cmd.fpu_op == iep_pkg::FPU_MUL || cmd.fpu_op == iep_pkg::FPU_DIV)
               ? x_reg : t_reg;

  iep_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.fpu_start),
    .op     (cmd.fpu_op),
    .a      (fpu_a),
    .b      (fpu_b),
    .done   (fpu_done),
    .result (fpu_result)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_reg  <= operand_bits;
      t_reg  <= operand_bits;
      op_reg <= op_in;
    end
    if (cmd.take_term) begin
      t_reg <= fpu_result;
    end
    if (cmd.commit_term) begin
      product_term <= t_reg;
    end
    if (cmd.load_out) begin
      result_bits <= ((running_sum[30:23] == 8'hFF) && (running_sum[22:0] != 23'd0))
                   ? iep_pkg::CANON_NAN : running_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= 32'd0;
      additive_minus <= 1'b0;
      term_pending   <= 1'b0;
      divide_pending <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.commit_term) begin
        term_pending   <= 1'b1;
        divide_pending <= (op_reg == iep_pkg::OP_DIVIDE);
      end
      if (cmd.commit_sum) begin
        running_sum    <= fpu_result;
        term_pending   <= 1'b0;
        divide_pending <= 1'b0;
        additive_minus <= (op_reg == iep_pkg::OP_MINUS);
      end
      if (cmd.load_out) begin
        // The end mark returns the expression state to its reset values.
        running_sum    <= 32'd0;
        additive_minus <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.term_pending   = term_pending;
    stat.divide_pending = divide_pending;
    stat.additive_minus = additive_minus;
    stat.op             = op_reg;
    stat.fpu_done       = fpu_done;
    stat.out_busy       = result_valid && result_stall;
  end

endmodule
`default_nettype wire

// ----- design/infix_expression_evaluator.sv -----
`default_nettype none
// Sequence: each item first completes a pending product term by a multiply or a divide
//   (plus normalising shifts, and prenormalising shifts for a divide). A times or divide
//   operator then keeps the result as the term; any other operator adds or subtracts it
//   into the running sum, and an end mark also loads the output register.
// Throughput: one item at a time; an end mark loads the output register, which frees
//   the input while the result waits. Reset (rst, synchronous) clears state.
// ---------------------------------------------------------------------------
// infix_expression_evaluator: two-level precedence float expression engine
// Accepts one operand with its following operator per transfer and emits
// the single precision value of the expression on the end mark.
// ---------------------------------------------------------------------------
module infix_expression_evaluator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        operand_valid,
  output logic             operand_stall,
  input  wire logic [31:0] operand_bits,
  input  wire logic [2:0]  next_op,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      result_bits
);

  iep_pkg::dp_cmd_t  cmd;
  iep_pkg::dp_stat_t stat;

  iep_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_stall (operand_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  iep_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operand_bits (operand_bits),
    .next_op      (next_op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_bits  (result_bits)
  );

endmodule
`default_nettype wire

// ----- design/iep_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// iep_checker: port-level checks for the expression evaluator
// Watches the handshakes and the result encoding at the top-level ports.
// ---------------------------------------------------------------------------
module iep_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        operand_valid,
  input wire logic        operand_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [31:0] result_bits
);

  // A held result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !rst && result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    !rst && result_valid && result_stall |=> $stable(result_bits))
    else $error("result changed while stalled");

  // Every NaN leaves the block in its canonical form.
  a_canon_nan: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_bits[30:23] == 8'hFF && result_bits[22:0] != 23'd0
    |-> result_bits == 32'h7FC0_0000)
    else $error("non-canonical NaN result");

  // The block works on one item at a time, so a transfer makes it busy.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    !rst && operand_valid && !operand_stall |=> operand_stall)
    else $error("second item taken straight after a transfer");

endmodule

bind infix_expression_evaluator iep_checker u_iep_checker (
  .clk           (clk),
  .rst           (rst),
  .operand_valid (operand_valid),
  .operand_stall (operand_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result_bits   (result_bits)
);
`default_nettype wire

// ----- verif/tb_infix_expression_evaluator.sv -----
// ---------------------------------------------------------------------------
// tb_infix_expression_evaluator: self-checking bench for the expression engine
// Sends directed and random infix expressions through the operand channel,
// predicts every end-of-expression value in single precision and checks
// each result transfer against it, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_infix_expression_evaluator;

  // Predicts expression values and holds the values still to come out.
  class expr_scoreboard;
    bit [31:0] pending_values[$];
    bit [31:0] sum_bits;
    bit        minus;
    bit [31:0] term_bits;
    bit        have_term;
    bit        have_divide;
    int        n_checked;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      sum_bits    = 32'h0000_0000;
      minus       = 1'b0;
      term_bits   = 32'h0000_0000;
      have_term   = 1'b0;
      have_divide = 1'b0;
    endfunction

    static function bit is_nan(bit [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Single to double is exact, so every operation can be carried out in
    // double and rounded once; double has enough bits that this is correct.
    static function real to_real(bit [31:0] b);
      real r;
      if (b[30:23] == 8'hFF) begin
        if (b[22:0] != 23'd0) return $bitstoreal(64'h7FF8_0000_0000_0000);
        return $bitstoreal({b[31], 11'h7FF, 52'd0});
      end
      if (b[30:23] == 8'h00) begin
        if (b[22:0] == 23'd0) return $bitstoreal({b[31], 63'd0});
        r = b[22:0] * $bitstoreal(64'h36A0_0000_0000_0000);
        return b[31] ? -r : r;
      end
      return $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0});
    endfunction

    static function bit [31:0] to_single(real r);
      bit [63:0] d;
      bit [63:0] sig;
      bit [63:0] kept;
      bit [63:0] rem;
      bit [63:0] half;
      bit [63:0] mag;
      int        e;
      int        sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF)
        return (d[51:0] != 52'd0) ? iep_pkg::CANON_NAN : {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e = int'(d[62:52]) - 1023;
      if (e > 127) return {d[63], 8'hFF, 23'd0};
      sig = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 54) return {d[63], 31'd0};
      kept = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      // A rounding carry walks into the exponent field by itself.
      if (e >= -126) mag = (64'(e + 126) << 23) + kept;
      else mag = kept;
      if (mag >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
      return {d[63], mag[30:0]};
    endfunction

    static function bit [31:0] divide(bit [31:0] num, bit [31:0] den);
      if (den[30:0] == 31'd0) begin
        if (is_nan(num) || num[30:0] == 31'd0) return iep_pkg::CANON_NAN;
        return {num[31] ^ den[31], 8'hFF, 23'd0};
      end
      return to_single(to_real(num) / to_real(den));
    endfunction

    function void note_item(bit [31:0] opnd, bit [2:0] op);
      bit [31:0] t;
      bit [31:0] v;
      if (!have_term) t = opnd;
      else if (have_divide) t = divide(term_bits, opnd);
      else t = to_single(to_real(term_bits) * to_real(opnd));
      if (op == iep_pkg::OP_TIMES || op == iep_pkg::OP_DIVIDE) begin
        term_bits   = t;
        have_term   = 1'b1;
        have_divide = (op == iep_pkg::OP_DIVIDE);
        return;
      end
      sum_bits = minus ? to_single(to_real(sum_bits) - to_real(t))
                       : to_single(to_real(sum_bits) + to_real(t));
      have_term   = 1'b0;
      have_divide = 1'b0;
      if (op == iep_pkg::OP_PLUS || op == iep_pkg::OP_MINUS) begin
        minus = (op == iep_pkg::OP_MINUS);
        return;
      end
      v = is_nan(sum_bits) ? iep_pkg::CANON_NAN : sum_bits;
      pending_values.push_back(v);
      clear_state();
    endfunction

    function bit check_result(bit [31:0] got, output string why);
      bit [31:0] want;
      if (pending_values.size() == 0) begin
        why = $sformatf("result_bits %08h with no expression outstanding", got);
        return 1'b0;
      end
      want = pending_values.pop_front();
      n_checked++;
      if (got !== want) begin
        why = $sformatf("result_bits %08h, expected %08h", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        operand_valid = 1'b0;
  logic        operand_stall;
  logic [31:0] operand_bits = 32'd0;
  logic [2:0]  next_op = 3'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] result_bits;

  expr_scoreboard sb = new();
  int  fails = 0;
  int  items_sent = 0;
  int  exprs_sent = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  infix_expression_evaluator dut (
    .clk          (clk),
    .rst          (rst),
    .operand_valid(operand_valid),
    .operand_stall(operand_stall),
    .operand_bits (operand_bits),
    .next_op      (next_op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_bits  (result_bits)
  );

  always #4 clk = ~clk;

  initial begin
    #(8 * 1_500_000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk) begin
    string why;
    if (!rst && result_valid && !result_stall) begin
      if (!sb.check_result(result_bits, why)) report_mismatch(why);
    end
  end

  // Receiver: random stall bursts, long hold-offs on request, none late on.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall = 1'b1;
        repeat (400) @(negedge clk);
        result_stall = 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        result_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        result_stall = 1'b0;
      end
    end
  end

  task automatic send_item(bit [31:0] v, bit [2:0] op);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      operand_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    operand_valid = 1'b1;
    operand_bits  = v;
    next_op       = op;
    do @(posedge clk); while (operand_stall);
    sb.note_item(v, op);
    items_sent++;
    if (op != iep_pkg::OP_PLUS && op != iep_pkg::OP_MINUS &&
        op != iep_pkg::OP_TIMES && op != iep_pkg::OP_DIVIDE)
      exprs_sent++;
  endtask

  function automatic bit [31:0] pick_operand();
    bit [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 15))
      0: v = {v[31], 31'd0};
      1: v = {v[31], 8'hFF, 23'd0};
      2: v = {v[31], 8'hFF, v[22:1], 1'b1};
      3: v = {v[31], 8'h00, v[22:0]};
      4: ;
      5: v = {v[31], 8'($urandom_range(240, 254)), v[22:0]};
      6: v = {v[31], 8'($urandom_range(1, 12)), v[22:0]};
      default: v = {v[31], 8'($urandom_range(118, 136)), v[22:0]};
    endcase
    return v;
  endfunction

  initial begin
    int        len;
    bit [2:0]  last_op;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Lone negative zero.
    send_item(32'h8000_0000, iep_pkg::OP_END);
    // Precedence: 1 + 2 * 3 - 0.5.
    send_item(32'h3F80_0000, iep_pkg::OP_PLUS);
    send_item(32'h4000_0000, iep_pkg::OP_TIMES);
    send_item(32'h4040_0000, iep_pkg::OP_MINUS);
    send_item(32'h3F00_0000, iep_pkg::OP_END);
    // Division by zero in its forms, ended with the end mark and the unused operator codes.
    send_item(32'h4040_0000, iep_pkg::OP_DIVIDE);
    send_item(32'h0000_0000, iep_pkg::OP_END);
    send_item(32'h0000_0000, iep_pkg::OP_DIVIDE);
    send_item(32'h8000_0000, 3'd5);
    send_item(32'h7FC0_0001, iep_pkg::OP_DIVIDE);
    send_item(32'h0000_0000, 3'd6);
    send_item(32'hFF7F_FFFF, iep_pkg::OP_DIVIDE);
    send_item(32'h0000_0000, 3'd7);
    // Overflow, underflow and infinities.
    send_item(32'h7F7F_FFFF, iep_pkg::OP_TIMES);
    send_item(32'h7F7F_FFFF, iep_pkg::OP_END);
    send_item(32'h0000_0001, iep_pkg::OP_TIMES);
    send_item(32'h3F00_0000, iep_pkg::OP_PLUS);
    send_item(32'hFFFF_FFFF, iep_pkg::OP_END);
    send_item(32'h7F80_0000, iep_pkg::OP_MINUS);
    send_item(32'h7F80_0000, iep_pkg::OP_END);
    send_item(32'h4000_0000, iep_pkg::OP_DIVIDE);
    send_item(32'h4040_0000, iep_pkg::OP_TIMES);
    send_item(32'h4040_0000, iep_pkg::OP_MINUS);
    send_item(32'hFF80_0000, iep_pkg::OP_END);

    while (items_sent < 1450) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len - 1; i++)
        send_item(pick_operand(),
                  3'($urandom_range(iep_pkg::OP_PLUS, iep_pkg::OP_DIVIDE)));
      last_op = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                            : iep_pkg::OP_END;
      send_item(pick_operand(), last_op);
      if (items_sent >= 600 && items_sent < 610) hold_req = 1'b1;
      if (items_sent > 1250) calm = 1'b1;
    end
    @(negedge clk);
    operand_valid = 1'b0;

    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Sent %0d operand transfers forming %0d expressions, checked %0d results.",
             items_sent, exprs_sent, sb.n_checked);
    $display("Covered precedence, zero division, overflow, subnormals and NaN values.");
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- infix_expression_evaluator.f -----
design/iep_pkg.sv
design/iep_fpu.sv
design/iep_ctrl.sv
design/iep_dp.sv
design/infix_expression_evaluator.sv
design/iep_checker.sv
verif/tb_infix_expression_evaluator.sv
